[src/amg_pkg.sv]
package amg_pkg;

    localparam int VERTEX_BITS      = 5;
    localparam int WEIGHT_IO_BITS   = 16;
    localparam int COUNT_BITS       = 9;
    localparam int APB_ADDR_BITS    = 3;
    localparam int APB_DATA_BITS    = 32;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_WEIGHT_BITS  = 16;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = 9'd511;
    localparam logic [VERTEX_BITS-1:0] VCOUNT_RESET = 5'd16;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_QUERY  = 2'd2;
    localparam cmd_t CMD_LIST   = 2'd3;

    localparam logic REG_DIRECTED = 1'b0;
    localparam logic REG_VCOUNT   = 1'b1;

    typedef logic [1:0] res_sel_t;
    localparam res_sel_t RES_PAIR  = 2'd0;
    localparam res_sel_t RES_ERR   = 2'd1;
    localparam res_sel_t RES_PEND  = 2'd2;
    localparam res_sel_t RES_EMPTY = 2'd3;

    typedef struct packed {
        cmd_t                           command;
        logic [VERTEX_BITS-1:0]         from_vertex;
        logic [VERTEX_BITS-1:0]         to_vertex;
        logic signed [WEIGHT_IO_BITS-1:0] edge_weight;
    } in_item_t;

    typedef struct packed {
        logic                             status;
        logic [VERTEX_BITS-1:0]           out_from;
        logic [VERTEX_BITS-1:0]           out_to;
        logic signed [WEIGHT_IO_BITS-1:0] out_weight;
        logic                             connected;
        logic [COUNT_BITS-1:0]            edges_total;
        logic                             last_of_run;
    } out_item_t;

    typedef struct packed {
        logic     latch_in;
        logic     clr_step;
        logic     rd_pair;
        logic     rd_col;
        logic     wr_pair;
        logic     wr_mirror;
        logic     cnt_upd;
        logic     col_inc;
        logic     pend_load;
        logic     out_load;
        res_sel_t res_sel;
        logic     res_last;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic range_ok;
        cmd_t op;
        logic directed;
        logic col_last;
        logic rd_nonzero;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

[src/amg_regs.sv]
module amg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [amg_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [amg_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [amg_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output logic                               directed,
    output logic [amg_pkg::VERTEX_BITS-1:0]    vertex_count
);
    import amg_pkg::*;

    logic                   directed_reg;
    logic                   directed_next;
    logic [VERTEX_BITS-1:0] vcount_reg;
    logic [VERTEX_BITS-1:0] vcount_next;
    logic                   wr_en;
    logic                   reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    always_comb
    begin
        directed_next = directed_reg;
        vcount_next   = vcount_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_DIRECTED: directed_next = pwdata[0];
                REG_VCOUNT:   vcount_next   = pwdata[VERTEX_BITS-1:0];
                default:      directed_next = directed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg <= 1'b0;
            vcount_reg   <= VCOUNT_RESET;
        end
        else
        begin
            directed_reg <= directed_next;
            vcount_reg   <= vcount_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_DIRECTED: prdata = {{(APB_DATA_BITS-1){1'b0}}, directed_reg};
            REG_VCOUNT:   prdata = {{(APB_DATA_BITS-VERTEX_BITS){1'b0}}, vcount_reg};
            default:      prdata = '0;
        endcase
    end

    assign directed     = directed_reg;
    assign vertex_count = vcount_reg;

endmodule

[src/amg_datapath.sv]
module amg_datapath #(
    parameter int MAX_VERTICES = amg_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = amg_pkg::DEF_WEIGHT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  amg_pkg::in_item_t               in_item,
    input  logic                            directed,
    input  logic [amg_pkg::VERTEX_BITS-1:0] vertex_count,
    input  amg_pkg::dp_cmd_t                dcmd,
    output amg_pkg::dp_stat_t               dstat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output amg_pkg::out_item_t              out_data
);
    import amg_pkg::*;

    localparam int IDX_BITS  = $clog2(MAX_VERTICES);
    localparam int ADDR_BITS = 2 * IDX_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int CW        = VERTEX_BITS + IDX_BITS;
    localparam int EXT_BITS  = (WEIGHT_BITS > WEIGHT_IO_BITS) ? WEIGHT_BITS : WEIGHT_IO_BITS;

    logic [WEIGHT_BITS-1:0] mem [DEPTH];

    cmd_t                   cmd_reg;
    logic [VERTEX_BITS-1:0] from_reg;
    logic [VERTEX_BITS-1:0] to_reg;
    logic [WEIGHT_BITS-1:0] wt_reg;
    logic [WEIGHT_BITS-1:0] rd_data_reg;
    logic [WEIGHT_BITS-1:0] pair_w_reg;
    logic [VERTEX_BITS-1:0] pend_col_reg;
    logic [WEIGHT_BITS-1:0] pend_w_reg;
    out_item_t              out_data_reg;

    logic [COUNT_BITS-1:0]  counter_reg;
    logic [COUNT_BITS-1:0]  counter_next;
    logic [ADDR_BITS-1:0]   clr_addr_reg;
    logic [IDX_BITS-1:0]    col_reg;
    logic                   pend_valid_reg;
    logic                   out_valid_reg;

    logic signed [EXT_BITS-1:0] ext_in;
    logic signed [EXT_BITS-1:0] ext_out;
    logic [CW-1:0]          lim;
    logic [CW-1:0]          from_w;
    logic [CW-1:0]          to_w;
    logic [CW-1:0]          fm1;
    logic [CW-1:0]          tm1;
    logic [CW-1:0]          next_col;
    logic [IDX_BITS-1:0]    fi;
    logic [IDX_BITS-1:0]    ti;
    logic                   from_ok;
    logic                   to_ok;
    cmd_t                   op;
    logic [WEIGHT_BITS-1:0] new_w;
    logic                   we;
    logic                   re;
    logic [ADDR_BITS-1:0]   waddr;
    logic [ADDR_BITS-1:0]   raddr;
    logic [WEIGHT_BITS-1:0] wdata;
    logic [WEIGHT_BITS-1:0] sel_w;
    logic [VERTEX_BITS-1:0] sel_to;
    logic                   out_free;

    assign ext_in = EXT_BITS'(in_item.edge_weight);

    assign lim = (CW'(vertex_count) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                         : CW'(vertex_count);
    assign from_w   = CW'(from_reg);
    assign to_w     = CW'(to_reg);
    assign from_ok  = (from_w != '0) && (from_w <= lim);
    assign to_ok    = (to_w != '0) && (to_w <= lim);
    assign fm1      = from_w - CW'(1);
    assign tm1      = to_w - CW'(1);
    assign fi       = fm1[IDX_BITS-1:0];
    assign ti       = tm1[IDX_BITS-1:0];
    assign next_col = CW'(col_reg) + CW'(1);

    assign op    = ((cmd_reg == CMD_ADD) && (wt_reg == '0)) ? CMD_REMOVE : cmd_reg;
    assign new_w = (op == CMD_ADD) ? wt_reg : '0;

    always_comb
    begin
        we    = dcmd.clr_step || dcmd.wr_pair || dcmd.wr_mirror;
        waddr = {fi, ti};
        wdata = new_w;
        priority if (dcmd.clr_step)
        begin
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else if (dcmd.wr_mirror)
        begin
            waddr = {ti, fi};
        end
        else
        begin
            waddr = {fi, ti};
        end
    end

    assign re    = dcmd.rd_pair || dcmd.rd_col;
    assign raddr = dcmd.rd_col ? {fi, col_reg} : {fi, ti};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        counter_next = counter_reg;
        if (dcmd.cnt_upd)
        begin
            if ((op == CMD_ADD) && (rd_data_reg == '0) && (counter_reg != COUNT_MAX))
            begin
                counter_next = counter_reg + COUNT_BITS'(1);
            end
            else if ((op == CMD_REMOVE) && (rd_data_reg != '0) && (counter_reg != '0))
            begin
                counter_next = counter_reg - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.latch_in)
        begin
            cmd_reg  <= in_item.command;
            from_reg <= in_item.from_vertex;
            to_reg   <= in_item.to_vertex;
            wt_reg   <= ext_in[WEIGHT_BITS-1:0];
        end
        if (dcmd.cnt_upd)
        begin
            pair_w_reg <= (op == CMD_QUERY) ? rd_data_reg : new_w;
        end
        if (dcmd.pend_load)
        begin
            pend_col_reg <= next_col[VERTEX_BITS-1:0];
            pend_w_reg   <= rd_data_reg;
        end
        if (dcmd.out_load)
        begin
            out_data_reg.status      <= (dcmd.res_sel == RES_ERR);
            out_data_reg.out_from    <= from_reg;
            out_data_reg.out_to      <= sel_to;
            out_data_reg.out_weight  <= ext_out[WEIGHT_IO_BITS-1:0];
            out_data_reg.connected   <= (sel_w != '0);
            out_data_reg.edges_total <= counter_reg;
            out_data_reg.last_of_run <= dcmd.res_last;
        end
    end

    always_comb
    begin
        unique case (dcmd.res_sel)
            RES_PAIR:
            begin
                sel_w  = pair_w_reg;
                sel_to = to_reg;
            end
            RES_ERR:
            begin
                sel_w  = '0;
                sel_to = to_reg;
            end
            RES_PEND:
            begin
                sel_w  = pend_w_reg;
                sel_to = pend_col_reg;
            end
            default:
            begin
                sel_w  = '0;
                sel_to = '0;
            end
        endcase
    end

    assign ext_out = EXT_BITS'($signed(sel_w));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            clr_addr_reg   <= '0;
            col_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            if (dcmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            end
            if (dcmd.latch_in)
            begin
                col_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (dcmd.col_inc)
                begin
                    col_reg <= col_reg + IDX_BITS'(1);
                end
                if (dcmd.pend_load)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (dcmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        dstat.clr_done   = (clr_addr_reg == {ADDR_BITS{1'b1}});
        dstat.range_ok   = (cmd_reg == CMD_LIST) ? from_ok : (from_ok && to_ok);
        dstat.op         = op;
        dstat.directed   = directed;
        dstat.col_last   = (CW'(col_reg) == (lim - CW'(1)));
        dstat.rd_nonzero = (rd_data_reg != '0);
        dstat.pend_valid = pend_valid_reg;
        dstat.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/amg_ctrl.sv]
module amg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  amg_pkg::dp_stat_t dstat,
    output amg_pkg::dp_cmd_t  dcmd
);
    import amg_pkg::*;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DECODE   = 4'd2;
    localparam logic [3:0] ST_MODIFY   = 4'd3;
    localparam logic [3:0] ST_MIRROR   = 4'd4;
    localparam logic [3:0] ST_EMIT     = 4'd5;
    localparam logic [3:0] ST_ERR      = 4'd6;
    localparam logic [3:0] ST_LIST_RD  = 4'd7;
    localparam logic [3:0] ST_LIST_CHK = 4'd8;
    localparam logic [3:0] ST_LIST_END = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        dcmd       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dcmd.clr_step = 1'b1;
                if (dstat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                dcmd.latch_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!dstat.range_ok)
                begin
                    state_next = ST_ERR;
                end
                else if (dstat.op == CMD_LIST)
                begin
                    state_next = ST_LIST_RD;
                end
                else
                begin
                    dcmd.rd_pair = 1'b1;
                    state_next   = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                dcmd.cnt_upd = 1'b1;
                if (dstat.op != CMD_QUERY)
                begin
                    dcmd.wr_pair = 1'b1;
                end
                if ((dstat.op != CMD_QUERY) && !dstat.directed)
                begin
                    state_next = ST_MIRROR;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_MIRROR:
            begin
                dcmd.wr_mirror = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                dcmd.res_sel  = RES_PAIR;
                dcmd.res_last = 1'b1;
                if (dstat.out_free)
                begin
                    dcmd.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                dcmd.res_sel  = RES_ERR;
                dcmd.res_last = 1'b1;
                if (dstat.out_free)
                begin
                    dcmd.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LIST_RD:
            begin
                dcmd.rd_col = 1'b1;
                state_next  = ST_LIST_CHK;
            end
            ST_LIST_CHK:
            begin
                dcmd.res_sel = RES_PEND;
                if (!dstat.rd_nonzero || !dstat.pend_valid || dstat.out_free)
                begin
                    if (dstat.rd_nonzero)
                    begin
                        dcmd.pend_load = 1'b1;
                        dcmd.out_load  = dstat.pend_valid;
                    end
                    if (dstat.col_last)
                    begin
                        state_next = ST_LIST_END;
                    end
                    else
                    begin
                        dcmd.col_inc = 1'b1;
                        state_next   = ST_LIST_RD;
                    end
                end
            end
            ST_LIST_END:
            begin
                dcmd.res_sel  = dstat.pend_valid ? RES_PEND : RES_EMPTY;
                dcmd.res_last = 1'b1;
                if (dstat.out_free)
                begin
                    dcmd.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/adjacency_matrix_graph_store.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  in_data (in_item_t)
// out       output     out_valid/out_ready  out_data (out_item_t)
// config    input      APB psel/penable     paddr, pwdata, prdata
//
// After reset the weight table is swept to zero, one entry per cycle, over all
// 2**(2*clog2(MAX_VERTICES)) entries (256 for 16 vertices); no input is accepted then.
// Add, remove and query pass decode, modify, mirror (undirected writes) and emit states;
// a vertex out of range goes to error. Listing reads one column at a time (one read port).
// A result waits in the output register; a stalled output holds back the next result.
module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = amg_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = amg_pkg::DEF_WEIGHT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  amg_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output amg_pkg::out_item_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [amg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [amg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [amg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import amg_pkg::*;

    logic                   directed;
    logic [VERTEX_BITS-1:0] vertex_count;
    dp_cmd_t                dcmd;
    dp_stat_t               dstat;

    amg_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .directed     (directed),
        .vertex_count (vertex_count)
    );

    amg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .dstat    (dstat),
        .dcmd     (dcmd)
    );

    amg_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_data),
        .directed     (directed),
        .vertex_count (vertex_count),
        .dcmd         (dcmd),
        .dstat        (dstat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

[verif/tb_adjacency_matrix_graph_store.sv]
`timescale 1ns / 100ps

module tb_adjacency_matrix_graph_store;
    import amg_pkg::*;

    localparam int NUM_VERTICES   = DEF_MAX_VERTICES;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 80;
    localparam int REPORT_LIMIT   = 10;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_item_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_item_t                out_data;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr     = '0;
    logic [APB_DATA_BITS-1:0] pwdata    = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Shadow copy of the graph held by the block.
    logic signed [WEIGHT_IO_BITS-1:0] wt_table [NUM_VERTICES][NUM_VERTICES];
    logic [COUNT_BITS-1:0]            edge_cnt;
    logic                             mode_directed;
    logic [VERTEX_BITS-1:0]           vertex_limit;
    out_item_t                        graph_replies_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    adjacency_matrix_graph_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [VERTEX_BITS-1:0] active_span();
        return (vertex_limit > NUM_VERTICES) ? VERTEX_BITS'(NUM_VERTICES) : vertex_limit;
    endfunction

    function automatic logic in_span(input logic [VERTEX_BITS-1:0] v);
        return (v >= 1) && (v <= active_span());
    endfunction

    function automatic void apply_graph_command(input in_item_t req);
        logic [VERTEX_BITS-1:0]           span;
        logic [VERTEX_BITS-1:0]           last_col;
        logic [VERTEX_BITS-1:0]           src;
        logic [VERTEX_BITS-1:0]           dst;
        logic signed [WEIGHT_IO_BITS-1:0] wt_new;
        out_item_t                        res;
        span = active_span();
        src = req.from_vertex;
        dst = req.to_vertex;
        res = '0;
        res.out_from = src;
        res.out_to = dst;
        res.last_of_run = 1'b1;
        if (req.command == CMD_LIST && in_span(src))
        begin
            last_col = '0;
            for (int j = 1; j <= span; j++)
            begin
                if (wt_table[src-1][j-1] != 0)
                    last_col = VERTEX_BITS'(j);
            end
            res.edges_total = edge_cnt;
            if (last_col == 0)
            begin
                res.out_to = '0;
                graph_replies_due.push_back(res);
            end
            else
            begin
                for (int j = 1; j <= span; j++)
                begin
                    if (wt_table[src-1][j-1] != 0)
                    begin
                        res.out_to = VERTEX_BITS'(j);
                        res.out_weight = wt_table[src-1][j-1];
                        res.connected = 1'b1;
                        res.last_of_run = (VERTEX_BITS'(j) == last_col);
                        graph_replies_due.push_back(res);
                    end
                end
            end
        end
        else if (!in_span(src) || (req.command != CMD_LIST && !in_span(dst)))
        begin
            res.status = 1'b1;
            res.edges_total = edge_cnt;
            graph_replies_due.push_back(res);
        end
        else
        begin
            if (req.command == CMD_ADD || req.command == CMD_REMOVE)
            begin
                wt_new = (req.command == CMD_ADD) ? req.edge_weight : '0;
                if (wt_table[src-1][dst-1] == 0 && wt_new != 0 && edge_cnt < COUNT_MAX)
                    edge_cnt++;
                else if (wt_table[src-1][dst-1] != 0 && wt_new == 0 && edge_cnt > 0)
                    edge_cnt--;
                wt_table[src-1][dst-1] = wt_new;
                if (!mode_directed)
                    wt_table[dst-1][src-1] = wt_new;
            end
            res.out_weight = wt_table[src-1][dst-1];
            res.connected = (res.out_weight != 0);
            res.edges_total = edge_cnt;
            graph_replies_due.push_back(res);
        end
    endfunction

    function automatic void check_reply(input out_item_t got);
        out_item_t want;
        logic      same;
        if (graph_replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected result transfer with nothing pending: %h", got);
        end
        else
        begin
            want = graph_replies_due.pop_front();
            same = (got.status === want.status) && (got.out_from === want.out_from)
                && (got.out_to === want.out_to) && (got.out_weight === want.out_weight)
                && (got.connected === want.connected)
                && (got.edges_total === want.edges_total)
                && (got.last_of_run === want.last_of_run);
            if (!same)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch: expected st=%0d from=%0d to=%0d w=%0d ",
                        "conn=%0d total=%0d last=%0d, got st=%0d from=%0d to=%0d w=%0d ",
                        "conn=%0d total=%0d last=%0d"},
                        want.status, want.out_from, want.out_to, want.out_weight,
                        want.connected, want.edges_total, want.last_of_run,
                        got.status, got.out_from, got.out_to, got.out_weight,
                        got.connected, got.edges_total, got.last_of_run);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_reply(out_data);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_adjacency_matrix_graph_store: FAIL");
            $finish;
        end
    end

    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_graph_command(req);
    endtask

    task automatic settle_graph();
        in_valid <= 1'b0;
        while (graph_replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [APB_DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_DIRECTED)
            mode_directed = value[0];
        else
            vertex_limit = value[VERTEX_BITS-1:0];
    endtask

    task automatic cfg_read_check(input logic idx);
        logic [APB_DATA_BITS-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        want = (idx == REG_DIRECTED) ? APB_DATA_BITS'(mode_directed)
                                     : APB_DATA_BITS'(vertex_limit);
        if (prdata !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("register read mismatch at %0d: expected %h got %h",
                    {idx, 2'b00}, want, prdata);
        end
    endtask

    task automatic cfg_idle();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic in_item_t make_request(input cmd_t op, input int src, input int dst,
                                              input int wt);
        in_item_t r;
        r.command = op;
        r.from_vertex = VERTEX_BITS'(src);
        r.to_vertex = VERTEX_BITS'(dst);
        r.edge_weight = WEIGHT_IO_BITS'(wt);
        return r;
    endfunction

    function automatic logic [VERTEX_BITS-1:0] pick_vertex();
        if (active_span() != 0 && $urandom_range(99) < 85)
            return VERTEX_BITS'($urandom_range(active_span(), 1));
        return VERTEX_BITS'($urandom_range(31));
    endfunction

    function automatic in_item_t random_request();
        in_item_t r;
        int       pick;
        pick = $urandom_range(99);
        r.command = (pick < 40) ? CMD_ADD : (pick < 55) ? CMD_REMOVE :
                    (pick < 78) ? CMD_QUERY : CMD_LIST;
        r.from_vertex = pick_vertex();
        r.to_vertex = pick_vertex();
        case ($urandom_range(5))
            0: r.edge_weight = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: r.edge_weight = '0;
            2, 3: r.edge_weight = WEIGHT_IO_BITS'($urandom_range(20, 1));
            default: r.edge_weight = WEIGHT_IO_BITS'($urandom);
        endcase
        return r;
    endfunction

    task automatic test_register_readback();
        cfg_read_check(REG_DIRECTED);
        cfg_read_check(REG_VCOUNT);
        cfg_write(REG_DIRECTED, 32'd1);
        cfg_write(REG_VCOUNT, 32'd9);
        cfg_read_check(REG_DIRECTED);
        cfg_read_check(REG_VCOUNT);
        cfg_write(REG_DIRECTED, 32'd0);
        cfg_write(REG_VCOUNT, 32'd16);
        cfg_read_check(REG_VCOUNT);
        cfg_idle();
    endtask

    task automatic test_basic_commands();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_request(make_request(CMD_LIST, 1, 0, 0));
        send_request(make_request(CMD_ADD, 1, 16, 32767));
        send_request(make_request(CMD_QUERY, 16, 1, 0));
        send_request(make_request(CMD_ADD, 16, 1, -32768));
        send_request(make_request(CMD_QUERY, 1, 16, 0));
        send_request(make_request(CMD_ADD, 3, 3, 1));
        send_request(make_request(CMD_ADD, 1, 2, -1));
        send_request(make_request(CMD_LIST, 1, 0, 0));
        // Adding a zero weight behaves as a removal, on an empty and on a used entry.
        send_request(make_request(CMD_ADD, 2, 7, 0));
        send_request(make_request(CMD_ADD, 1, 2, 0));
        send_request(make_request(CMD_REMOVE, 16, 1, 0));
        send_request(make_request(CMD_QUERY, 1, 16, 0));
        send_request(make_request(CMD_LIST, 3, 0, 0));
        send_request(make_request(CMD_LIST, 16, 31, 21845));
        settle_graph();
    endtask

    task automatic test_out_of_range();
        send_request(make_request(CMD_ADD, 0, 5, 100));
        send_request(make_request(CMD_ADD, 5, 17, 100));
        send_request(make_request(CMD_REMOVE, 16, 0, 0));
        send_request(make_request(CMD_LIST, 0, 3, 0));
        send_request(make_request(CMD_LIST, 17, 9, 0));
        settle_graph();
    endtask

    task automatic test_vertex_count_limits();
        cfg_write(REG_DIRECTED, 32'd1);
        cfg_write(REG_VCOUNT, 32'd1);
        cfg_idle();
        send_request(make_request(CMD_ADD, 1, 1, 23130));
        send_request(make_request(CMD_ADD, 1, 2, 5));
        send_request(make_request(CMD_LIST, 1, 0, 0));
        settle_graph();
        cfg_write(REG_VCOUNT, 32'd0);
        cfg_idle();
        send_request(make_request(CMD_QUERY, 1, 1, 0));
        send_request(make_request(CMD_LIST, 1, 1, 0));
        settle_graph();
        cfg_write(REG_VCOUNT, 32'd31);
        cfg_idle();
        send_request(make_request(CMD_LIST, 3, 0, 0));
        send_request(make_request(CMD_QUERY, 1, 1, 0));
        settle_graph();
    endtask

    task automatic test_random_traffic(input int count, input int sender_idle,
                                       input int receiver_idle, input logic directed,
                                       input logic [VERTEX_BITS-1:0] vcount);
        cfg_write(REG_DIRECTED, APB_DATA_BITS'(directed));
        cfg_write(REG_VCOUNT, APB_DATA_BITS'(vcount));
        cfg_idle();
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        repeat (count)
            send_request(random_request());
        settle_graph();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_VERTICES; i++)
        begin
            for (int j = 0; j < NUM_VERTICES; j++)
                wt_table[i][j] = '0;
        end
        edge_cnt = '0;
        mode_directed = 1'b0;
        vertex_limit = VCOUNT_RESET;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        test_register_readback();
        test_basic_commands();
        test_out_of_range();
        test_vertex_count_limits();
        test_random_traffic(35, 29, 57, 1'b1, 5'd16);
        test_random_traffic(35, 57, 29, 1'b0, 5'd6);
        test_random_traffic(35, 0, 0, 1'b1, 5'd31);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb_adjacency_matrix_graph_store: PASS");
        else
            $display("tb_adjacency_matrix_graph_store: FAIL");
        $finish;
    end

endmodule
